/* hw/rtl/bptc_pkg.sv */
// ----------------------------------------------------------------------------
// bptc_pkg
// widths, constants and register codes for the pressure/temperature compensator
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int TEMP_W     = 20;
  localparam int PRES_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PIPE_DEPTH = 10;

  // intermediate widths
  localparam int PROD_W  = 40;
  localparam int SQ_W    = 48;
  localparam int TTERM_W = 17;
  localparam int OTERM_W = 33;
  localparam int STERM_W = 32;
  localparam int T2_W    = 17;
  localparam int OFF_W   = 42;
  localparam int SENS_W  = 40;
  localparam int DMAG_W  = 17;
  localparam int DSQ_W   = 34;
  localparam int CORR_W  = 38;
  localparam int SPLIT_W = 20;
  localparam int PLO_W   = 44;
  localparam int PHI_W   = 45;
  localparam int MUL_W   = 64;
  localparam int DIFF_W  = 48;

  localparam int T_SHIFT  = 23;
  localparam int O_SHIFT  = 7;
  localparam int S_SHIFT  = 8;
  localparam int T2_SHIFT = 31;
  localparam int P_SHIFT  = 21;
  localparam int Q_SHIFT  = 15;
  localparam int OFF_BASE_SHIFT  = 16;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int REF_SHIFT       = 8;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_DEEP = -20'sd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TEMP = 3'd2,
    REG_OFF_TEMP  = 3'd3,
    REG_REF_TEMP  = 3'd4,
    REG_TEMP_SLOPE = 3'd5,
    REG_SO_ENABLE = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

/* hw/rtl/bptc_in_if.sv */
// ----------------------------------------------------------------------------
// bptc_in_if
// raw conversion pair channel
// ----------------------------------------------------------------------------
`default_nettype none

interface bptc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bptc_pkg::RAW_W-1:0] raw_pressure;
  logic [bptc_pkg::RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bptc_out_if.sv */
// ----------------------------------------------------------------------------
// bptc_out_if
// compensated result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface bptc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bptc_pkg::TEMP_W-1:0] temp_centideg;
  logic signed [bptc_pkg::PRES_W-1:0] pressure_centimbar;

  modport source (output valid, output temp_centideg, output pressure_centimbar, input ready);
  modport sink   (input valid, input temp_centideg, input pressure_centimbar, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bptc_cfg_if.sv */
// ----------------------------------------------------------------------------
// bptc_cfg_if
// calibration register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface bptc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bptc_pkg::CFG_IDX_W-1:0] index;
  logic [bptc_pkg::COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/baro_pressure_temp_compensation_top.sv */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// second-order barometric pressure and temperature compensation pipeline
//
//   channel  dir  payload                                   handshake
//   in_chan  in   raw_pressure, raw_temperature (24 b each)  valid/ready
//   out_chan out  temp_centideg (20 b), pressure_centimbar   valid/ready
//   cfg_chan in   index (3 b), data (16 b)                   valid/ready
//
// one request per cycle while the output is not stalled
// ten register stages, each with its own valid bit and a ready chain,
// so bubbles are squeezed out and a stalled stage only holds what is behind it
// reset clears the valid bits and loads the register defaults
// config writes are always taken, cfg_chan.ready is tied high
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation_top (
  input  logic        clk,
  input  logic        rst_n,
  bptc_cfg_if.sink    cfg_chan,
  bptc_in_if.sink     in_chan,
  bptc_out_if.source  out_chan
);

  localparam int D = bptc_pkg::PIPE_DEPTH;

  // calibration registers
  logic [bptc_pkg::COEF_W-1:0] sens_r, offset_r, sens_temp_r, off_temp_r;
  logic [bptc_pkg::COEF_W-1:0] ref_temp_r, temp_slope_r;
  logic                        so_en_r;

  // pipeline control
  logic [D-1:0] vld_r;
  logic [D-1:0] vld_src;
  logic [D:0]   rdy;

  // stage 1
  logic [bptc_pkg::RAW_W-1:0] s1_d1_r, s1_mag_r, s1_mag_nxt;
  logic                       s1_below_r, s1_below_nxt;
  // stage 2
  logic [bptc_pkg::RAW_W-1:0]   s2_d1_r;
  logic                         s2_below_r;
  logic [bptc_pkg::TTERM_W-1:0] s2_tterm_r, s2_tterm_nxt;
  logic [bptc_pkg::OTERM_W-1:0] s2_oterm_r, s2_oterm_nxt;
  logic [bptc_pkg::STERM_W-1:0] s2_sterm_r, s2_sterm_nxt;
  logic [bptc_pkg::T2_W-1:0]    s2_t2_r, s2_t2_nxt;
  logic [bptc_pkg::PROD_W-1:0]  t_prod, o_prod, s_prod;
  logic [bptc_pkg::SQ_W-1:0]    sq_prod;
  // stage 3
  logic [bptc_pkg::RAW_W-1:0]         s3_d1_r;
  logic [bptc_pkg::T2_W-1:0]          s3_t2_r;
  logic signed [bptc_pkg::TEMP_W-1:0] s3_temp_r, s3_temp_nxt;
  logic [bptc_pkg::OFF_W-1:0]         s3_off_r, s3_off_nxt, off_base;
  logic [bptc_pkg::SENS_W-1:0]        s3_sens_r, s3_sens_nxt, sens_base;
  // stage 4
  logic [bptc_pkg::RAW_W-1:0]         s4_d1_r;
  logic signed [bptc_pkg::TEMP_W-1:0] s4_temp_r;
  logic [bptc_pkg::OFF_W-1:0]         s4_off_r;
  logic [bptc_pkg::SENS_W-1:0]        s4_sens_r;
  logic [bptc_pkg::T2_W-1:0]          s4_t2_r, s4_t2_nxt;
  logic [bptc_pkg::DMAG_W-1:0]        s4_dmag_r, s4_dmag_nxt, s4_emag_r, s4_emag_nxt;
  logic [bptc_pkg::TEMP_W-1:0]        dmag_full, emag_full;
  logic                               low_temp, deep_temp;
  // stage 5
  logic [bptc_pkg::RAW_W-1:0]         s5_d1_r;
  logic signed [bptc_pkg::TEMP_W-1:0] s5_temp_r;
  logic [bptc_pkg::OFF_W-1:0]         s5_off_r;
  logic [bptc_pkg::SENS_W-1:0]        s5_sens_r;
  logic [bptc_pkg::T2_W-1:0]          s5_t2_r;
  logic [bptc_pkg::DSQ_W-1:0]         s5_dd_r, s5_dd_nxt, s5_ee_r, s5_ee_nxt;
  // stage 6
  logic [bptc_pkg::RAW_W-1:0]         s6_d1_r;
  logic signed [bptc_pkg::TEMP_W-1:0] s6_temp_r, s6_temp_nxt;
  logic [bptc_pkg::OFF_W-1:0]         s6_off_r;
  logic [bptc_pkg::SENS_W-1:0]        s6_sens_r;
  logic [bptc_pkg::CORR_W-1:0]        s6_off2_r, s6_off2_nxt, s6_sens2_r, s6_sens2_nxt;
  logic [bptc_pkg::CORR_W-2:0]        five_dd, seven_ee;
  logic [bptc_pkg::CORR_W-1:0]        eleven_ee;
  // stage 7
  logic [bptc_pkg::RAW_W-1:0]         s7_d1_r;
  logic signed [bptc_pkg::TEMP_W-1:0] s7_temp_r;
  logic [bptc_pkg::OFF_W-1:0]         s7_off_r, s7_off_nxt;
  logic [bptc_pkg::SENS_W-1:0]        s7_sens_r, s7_sens_nxt;
  // stage 8
  logic signed [bptc_pkg::TEMP_W-1:0]  s8_temp_r;
  logic [bptc_pkg::OFF_W-1:0]          s8_off_r;
  logic [bptc_pkg::PLO_W-1:0]          s8_plo_r, s8_plo_nxt;
  logic signed [bptc_pkg::PHI_W-1:0]   s8_phi_r, s8_phi_nxt;
  logic signed [bptc_pkg::SPLIT_W-1:0] sens_hi;
  // stage 9
  logic signed [bptc_pkg::TEMP_W-1:0] s9_temp_r;
  logic [bptc_pkg::OFF_W-1:0]         s9_off_r;
  logic [bptc_pkg::MUL_W-1:0]         s9_prod_r, s9_prod_nxt;
  // stage 10
  logic signed [bptc_pkg::TEMP_W-1:0] out_temp_r;
  logic signed [bptc_pkg::PRES_W-1:0] out_pres_r, out_pres_nxt;
  logic [bptc_pkg::MUL_W-bptc_pkg::P_SHIFT-1:0] p1;
  logic [bptc_pkg::DIFF_W-1:0]                  q_diff;

  // config writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r       <= '0;
      offset_r     <= '0;
      sens_temp_r  <= '0;
      off_temp_r   <= '0;
      ref_temp_r   <= '0;
      temp_slope_r <= '0;
      so_en_r      <= 1'b1;
    end else if (cfg_chan.valid) begin
      unique case (bptc_pkg::cfg_reg_t'(cfg_chan.index))
        bptc_pkg::REG_SENS:       sens_r       <= cfg_chan.data;
        bptc_pkg::REG_OFFSET:     offset_r     <= cfg_chan.data;
        bptc_pkg::REG_SENS_TEMP:  sens_temp_r  <= cfg_chan.data;
        bptc_pkg::REG_OFF_TEMP:   off_temp_r   <= cfg_chan.data;
        bptc_pkg::REG_REF_TEMP:   ref_temp_r   <= cfg_chan.data;
        bptc_pkg::REG_TEMP_SLOPE: temp_slope_r <= cfg_chan.data;
        bptc_pkg::REG_SO_ENABLE:  so_en_r      <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // ready chain, one bit per stage
  assign vld_src = {vld_r[D-2:0], in_chan.valid};

  always_comb begin
    rdy[D] = out_chan.ready;
    for (int k = D - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_chan.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < D; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_src[k];
        end
      end
    end
  end

  // datapath
  always_comb begin
    // stage 1: temperature difference as magnitude and sign
    s1_below_nxt = in_chan.raw_temperature < {ref_temp_r, 8'h00};
    s1_mag_nxt   = s1_below_nxt ? ({ref_temp_r, 8'h00} - in_chan.raw_temperature)
                                : (in_chan.raw_temperature - {ref_temp_r, 8'h00});

    // stage 2: products with the magnitude
    t_prod       = {16'd0, s1_mag_r} * {24'd0, temp_slope_r};
    o_prod       = {16'd0, s1_mag_r} * {24'd0, off_temp_r};
    s_prod       = {16'd0, s1_mag_r} * {24'd0, sens_temp_r};
    sq_prod      = {24'd0, s1_mag_r} * {24'd0, s1_mag_r};
    s2_tterm_nxt = t_prod[bptc_pkg::PROD_W-1:bptc_pkg::T_SHIFT];
    s2_oterm_nxt = o_prod[bptc_pkg::PROD_W-1:bptc_pkg::O_SHIFT];
    s2_sterm_nxt = s_prod[bptc_pkg::PROD_W-1:bptc_pkg::S_SHIFT];
    s2_t2_nxt    = sq_prod[bptc_pkg::SQ_W-1:bptc_pkg::T2_SHIFT];

    // stage 3: first-order temperature, offset and sensitivity
    off_base  = {10'd0, offset_r, 16'd0};
    sens_base = {9'd0, sens_r, 15'd0};
    if (s2_below_r) begin
      s3_temp_nxt = bptc_pkg::TEMP_REF - $signed({3'd0, s2_tterm_r});
      s3_off_nxt  = off_base - {9'd0, s2_oterm_r};
      s3_sens_nxt = sens_base - {8'd0, s2_sterm_r};
    end else begin
      s3_temp_nxt = bptc_pkg::TEMP_REF + $signed({3'd0, s2_tterm_r});
      s3_off_nxt  = off_base + {9'd0, s2_oterm_r};
      s3_sens_nxt = sens_base + {8'd0, s2_sterm_r};
    end

    // stage 4: distances below the two thresholds, zero when not applied
    low_temp    = so_en_r && (s3_temp_r < bptc_pkg::TEMP_REF);
    deep_temp   = so_en_r && (s3_temp_r < bptc_pkg::TEMP_DEEP);
    dmag_full   = bptc_pkg::TEMP_REF - s3_temp_r;
    emag_full   = bptc_pkg::TEMP_DEEP - s3_temp_r;
    s4_dmag_nxt = low_temp ? dmag_full[bptc_pkg::DMAG_W-1:0] : '0;
    s4_emag_nxt = deep_temp ? emag_full[bptc_pkg::DMAG_W-1:0] : '0;
    s4_t2_nxt   = low_temp ? s3_t2_r : '0;

    // stage 5: squares
    s5_dd_nxt = {17'd0, s4_dmag_r} * {17'd0, s4_dmag_r};
    s5_ee_nxt = {17'd0, s4_emag_r} * {17'd0, s4_emag_r};

    // stage 6: second-order corrections
    five_dd      = {1'b0, s5_dd_r, 2'b00} + {3'd0, s5_dd_r};
    seven_ee     = {s5_ee_r, 3'b000} - {3'd0, s5_ee_r};
    eleven_ee    = {1'b0, s5_ee_r, 3'b000} + {3'd0, s5_ee_r, 1'b0} + {4'd0, s5_ee_r};
    s6_off2_nxt  = {2'd0, five_dd[bptc_pkg::CORR_W-2:1]} + {1'b0, seven_ee};
    s6_sens2_nxt = {3'd0, five_dd[bptc_pkg::CORR_W-2:2]} + {1'b0, eleven_ee[bptc_pkg::CORR_W-1:1]};
    s6_temp_nxt  = s5_temp_r - $signed({3'd0, s5_t2_r});

    // stage 7: apply corrections
    s7_off_nxt  = s6_off_r - {4'd0, s6_off2_r};
    s7_sens_nxt = s6_sens_r - {2'd0, s6_sens2_r};

    // stage 8: split product d1 * sens
    sens_hi    = s7_sens_r[bptc_pkg::SENS_W-1:bptc_pkg::SPLIT_W];
    s8_plo_nxt = {20'd0, s7_d1_r} * {24'd0, s7_sens_r[bptc_pkg::SPLIT_W-1:0]};
    s8_phi_nxt = $signed({21'd0, s7_d1_r})
               * $signed({{25{sens_hi[bptc_pkg::SPLIT_W-1]}}, sens_hi});

    // stage 9: combine partial products
    s9_prod_nxt = {s8_phi_r[bptc_pkg::PLO_W-1:0], 20'd0} + {20'd0, s8_plo_r};

    // stage 10: floor shifts and offset
    p1           = s9_prod_r[bptc_pkg::MUL_W-1:bptc_pkg::P_SHIFT];
    q_diff       = {{5{p1[bptc_pkg::MUL_W-bptc_pkg::P_SHIFT-1]}}, p1}
                 - {{6{s9_off_r[bptc_pkg::OFF_W-1]}}, s9_off_r};
    out_pres_nxt = q_diff[bptc_pkg::Q_SHIFT+bptc_pkg::PRES_W-1:bptc_pkg::Q_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_d1_r    <= in_chan.raw_pressure;
      s1_mag_r   <= s1_mag_nxt;
      s1_below_r <= s1_below_nxt;
    end
    if (rdy[1]) begin
      s2_d1_r    <= s1_d1_r;
      s2_below_r <= s1_below_r;
      s2_tterm_r <= s2_tterm_nxt;
      s2_oterm_r <= s2_oterm_nxt;
      s2_sterm_r <= s2_sterm_nxt;
      s2_t2_r    <= s2_t2_nxt;
    end
    if (rdy[2]) begin
      s3_d1_r   <= s2_d1_r;
      s3_t2_r   <= s2_t2_r;
      s3_temp_r <= s3_temp_nxt;
      s3_off_r  <= s3_off_nxt;
      s3_sens_r <= s3_sens_nxt;
    end
    if (rdy[3]) begin
      s4_d1_r   <= s3_d1_r;
      s4_temp_r <= s3_temp_r;
      s4_off_r  <= s3_off_r;
      s4_sens_r <= s3_sens_r;
      s4_t2_r   <= s4_t2_nxt;
      s4_dmag_r <= s4_dmag_nxt;
      s4_emag_r <= s4_emag_nxt;
    end
    if (rdy[4]) begin
      s5_d1_r   <= s4_d1_r;
      s5_temp_r <= s4_temp_r;
      s5_off_r  <= s4_off_r;
      s5_sens_r <= s4_sens_r;
      s5_t2_r   <= s4_t2_r;
      s5_dd_r   <= s5_dd_nxt;
      s5_ee_r   <= s5_ee_nxt;
    end
    if (rdy[5]) begin
      s6_d1_r    <= s5_d1_r;
      s6_temp_r  <= s6_temp_nxt;
      s6_off_r   <= s5_off_r;
      s6_sens_r  <= s5_sens_r;
      s6_off2_r  <= s6_off2_nxt;
      s6_sens2_r <= s6_sens2_nxt;
    end
    if (rdy[6]) begin
      s7_d1_r   <= s6_d1_r;
      s7_temp_r <= s6_temp_r;
      s7_off_r  <= s7_off_nxt;
      s7_sens_r <= s7_sens_nxt;
    end
    if (rdy[7]) begin
      s8_temp_r <= s7_temp_r;
      s8_off_r  <= s7_off_r;
      s8_plo_r  <= s8_plo_nxt;
      s8_phi_r  <= s8_phi_nxt;
    end
    if (rdy[8]) begin
      s9_temp_r <= s8_temp_r;
      s9_off_r  <= s8_off_r;
      s9_prod_r <= s9_prod_nxt;
    end
    if (rdy[9]) begin
      out_temp_r <= s9_temp_r;
      out_pres_r <= out_pres_nxt;
    end
  end

  assign out_chan.valid              = vld_r[D-1];
  assign out_chan.temp_centideg      = out_temp_r;
  assign out_chan.pressure_centimbar = out_pres_r;

endmodule

`default_nettype wire

/* hw/rtl/bptc_checker.sv */
// ----------------------------------------------------------------------------
// bptc_checker
// port-level checks on request flow through the compensation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module bptc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bptc_pkg::TEMP_W-1:0] out_temp,
  input logic signed [bptc_pkg::PRES_W-1:0] out_pres
);

  localparam int CNT_W = $clog2(bptc_pkg::PIPE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(bptc_pkg::PIPE_DEPTH);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests inside the pipeline
  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= DEPTH)
    else $error("more requests in flight than stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == '0 |-> !out_valid)
    else $error("result without a request");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == DEPTH) && !out_ready |-> !in_ready)
    else $error("request taken into a full stalled pipeline");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_pres))
    else $error("stalled result changed");

endmodule

bind baro_pressure_temp_compensation_top bptc_checker u_bptc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_temp  (out_chan.temp_centideg),
  .out_pres  (out_chan.pressure_centimbar)
);

`default_nettype wire

/* sim/tb_baro_pressure_temp_compensation_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_top
// self-checking bench for the barometric compensation pipeline
//
// Raw pressure and temperature pairs go in as requests. A scoreboard predicts
// the compensated temperature and pressure for each one, using the calibration
// words it sees written. It then compares every result in order, field by field.
// Runs cover the reset defaults, a typical calibration set, all-ones and
// all-zero words, and randomised sets with the second-order correction on and
// off. Random gaps and stalls are applied on both sides.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation_top;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_SETS  = 8;
  localparam int SET_REQUESTS = 100;
  localparam logic [bptc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [bptc_pkg::RAW_W-1:0]     RAW_MAX   = '1;

  typedef logic [bptc_pkg::RAW_W-1:0]  raw_t;
  typedef logic [bptc_pkg::COEF_W-1:0] coef_t;

  typedef struct packed {
    logic signed [bptc_pkg::TEMP_W-1:0] temp_centideg;
    logic signed [bptc_pkg::PRES_W-1:0] pressure_centimbar;
  } reading_t;

  class bptc_scoreboard;
    longint   sens_w, off_w, sens_t_w, off_t_w, ref_w, slope_w;
    bit       so_enable;
    reading_t awaited[$];
    int       errors, requests, low_temp_cases, deep_cold_cases;

    function new();
      so_enable = 1'b1;
    endfunction

    function void set_reg(input logic [bptc_pkg::CFG_IDX_W-1:0] idx,
                          input logic [bptc_pkg::COEF_W-1:0] val);
      case (idx)
        bptc_pkg::REG_SENS:       sens_w    = longint'(val);
        bptc_pkg::REG_OFFSET:     off_w     = longint'(val);
        bptc_pkg::REG_SENS_TEMP:  sens_t_w  = longint'(val);
        bptc_pkg::REG_OFF_TEMP:   off_t_w   = longint'(val);
        bptc_pkg::REG_REF_TEMP:   ref_w     = longint'(val);
        bptc_pkg::REG_TEMP_SLOPE: slope_w   = longint'(val);
        bptc_pkg::REG_SO_ENABLE:  so_enable = val[0];
        default: ;
      endcase
    endfunction

    function void note_request(input logic [bptc_pkg::RAW_W-1:0] d1,
                               input logic [bptc_pkg::RAW_W-1:0] d2);
      longint   tref, raw_t, mag, temp, off, sens, t2, dev, off2, sens2, cold, p;
      bit       below;
      reading_t r;
      tref  = ref_w << bptc_pkg::REF_SHIFT;
      raw_t = longint'(d2);
      below = raw_t < tref;
      mag   = below ? tref - raw_t : raw_t - tref;
      // magnitude products truncate before the sign goes on
      temp  = (mag * slope_w) >> bptc_pkg::T_SHIFT;
      off   = (mag * off_t_w) >> bptc_pkg::O_SHIFT;
      sens  = (mag * sens_t_w) >> bptc_pkg::S_SHIFT;
      if (below) begin
        temp = bptc_pkg::TEMP_REF - temp;
        off  = (off_w << bptc_pkg::OFF_BASE_SHIFT) - off;
        sens = (sens_w << bptc_pkg::SENS_BASE_SHIFT) - sens;
      end else begin
        temp = bptc_pkg::TEMP_REF + temp;
        off  = (off_w << bptc_pkg::OFF_BASE_SHIFT) + off;
        sens = (sens_w << bptc_pkg::SENS_BASE_SHIFT) + sens;
      end
      if (so_enable && temp < bptc_pkg::TEMP_REF) begin
        low_temp_cases++;
        t2    = (mag * mag) >> bptc_pkg::T2_SHIFT;
        dev   = temp - bptc_pkg::TEMP_REF;
        off2  = (5 * dev * dev) >>> 1;
        sens2 = off2 >>> 1;
        if (temp < bptc_pkg::TEMP_DEEP) begin
          deep_cold_cases++;
          cold  = temp - bptc_pkg::TEMP_DEEP;
          cold  = cold * cold;
          off2  += 7 * cold;
          sens2 += (11 * cold) >>> 1;
        end
        temp -= t2;
        off  -= off2;
        sens -= sens2;
      end
      p = (longint'(d1) * sens) >>> bptc_pkg::P_SHIFT;
      p = (p - off) >>> bptc_pkg::Q_SHIFT;
      r.temp_centideg      = temp[bptc_pkg::TEMP_W-1:0];
      r.pressure_centimbar = p[bptc_pkg::PRES_W-1:0];
      awaited.push_back(r);
      requests++;
    endfunction

    function void check_result(input logic signed [bptc_pkg::TEMP_W-1:0] temp,
                               input logic signed [bptc_pkg::PRES_W-1:0] pres);
      reading_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: temp_centideg %0d, pressure_centimbar %0d", temp, pres);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (temp !== want.temp_centideg) begin
        $error("temp_centideg: expected %0d, got %0d", want.temp_centideg, temp);
        errors++;
      end
      if (pres !== want.pressure_centimbar) begin
        $error("pressure_centimbar: expected %0d, got %0d", want.pressure_centimbar, pres);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   in_no_gap;
  bit   out_no_stall;
  logic [bptc_pkg::COEF_W-1:0] cal_words [6];
  bptc_scoreboard sb = new();

  bptc_cfg_if cfg_chan ();
  bptc_in_if  in_chan ();
  bptc_out_if out_chan ();

  baro_pressure_temp_compensation_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready)
        sb.set_reg(cfg_chan.index, cfg_chan.data);
      if (in_chan.valid && in_chan.ready)
        sb.note_request(in_chan.raw_pressure, in_chan.raw_temperature);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.temp_centideg, out_chan.pressure_centimbar);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        idle = 0;
      else
        idle++;
    end
    $display("[baro_pressure_temp_compensation_top] ERROR");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_no_stall ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  task automatic send_sample(input logic [bptc_pkg::RAW_W-1:0] d1,
                             input logic [bptc_pkg::RAW_W-1:0] d2);
    int gap;
    gap = in_no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.raw_pressure    <= d1;
    in_chan.raw_temperature <= d2;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  task automatic write_reg(input logic [bptc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bptc_pkg::COEF_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
  endtask

  task automatic load_calibration(input bit so_en, input bit poke_spare);
    logic [bptc_pkg::COEF_W-1:0] en_word;
    en_word    = coef_t'($urandom_range(0, 16'hFFFF));
    en_word[0] = so_en;
    write_reg(bptc_pkg::REG_SENS, cal_words[0]);
    write_reg(bptc_pkg::REG_OFFSET, cal_words[1]);
    write_reg(bptc_pkg::REG_SENS_TEMP, cal_words[2]);
    write_reg(bptc_pkg::REG_OFF_TEMP, cal_words[3]);
    write_reg(bptc_pkg::REG_REF_TEMP, cal_words[4]);
    write_reg(bptc_pkg::REG_TEMP_SLOPE, cal_words[5]);
    write_reg(bptc_pkg::REG_SO_ENABLE, en_word);
    if (poke_spare)
      write_reg(REG_SPARE, coef_t'($urandom_range(0, 16'hFFFF)));
    cfg_chan.valid <= 1'b0;
  endtask

  // drop valid and wait for the pipeline to empty
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_typical();
    cal_words[0] = 16'd40127;
    cal_words[1] = 16'd36924;
    cal_words[2] = 16'd23317;
    cal_words[3] = 16'd23282;
    cal_words[4] = 16'd33464;
    cal_words[5] = 16'd28312;
  endtask

  function automatic logic [bptc_pkg::COEF_W-1:0] pick_word(
      input logic [bptc_pkg::COEF_W-1:0] typical);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return coef_t'(typical + $urandom_range(0, 4095) - 2048);
      default: return coef_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // temperatures around the reference point, some deep cold, some anywhere in range
  task automatic random_pair(output logic [bptc_pkg::RAW_W-1:0] d1,
                             output logic [bptc_pkg::RAW_W-1:0] d2);
    longint tref, span, v;
    tref = sb.ref_w << bptc_pkg::REF_SHIFT;
    d1   = raw_t'($urandom_range(0, RAW_MAX));
    span = longint'(1) << $urandom_range(0, bptc_pkg::RAW_W - 1);
    case ($urandom_range(0, 4))
      0:       v = longint'($urandom_range(0, RAW_MAX));
      1, 2:    v = tref + longint'($urandom_range(0, span)) - span / 2;
      3:       v = tref - longint'($urandom_range(0, 1 << 23));
      default: begin
        v  = longint'($urandom_range(0, RAW_MAX));
        d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
      end
    endcase
    if (v < 0)
      v = 0;
    else if (v > longint'(RAW_MAX))
      v = longint'(RAW_MAX);
    d2 = v[bptc_pkg::RAW_W-1:0];
  endtask

  initial begin
    logic [bptc_pkg::RAW_W-1:0] d1, d2;
    int cal_sets;
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.raw_pressure    <= '0;
    in_chan.raw_temperature <= '0;
    cfg_chan.valid          <= 1'b0;
    cfg_chan.index          <= '0;
    cfg_chan.data           <= '0;
    cal_sets = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    send_sample('0, '0);
    send_sample(RAW_MAX, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(raw_t'($urandom_range(0, RAW_MAX)), raw_t'($urandom_range(0, RAW_MAX)));
    settle();

    // typical words, reference point at 8566784
    set_typical();
    load_calibration(1'b1, 1'b1);
    cal_sets++;
    send_sample(24'd9085466, 24'd8569150);
    send_sample(24'd9085466, 24'd8566784);
    send_sample(24'd9085466, 24'd8566783);
    send_sample(24'd9085466, 24'd8166784);
    send_sample(24'd9085466, 24'd6566784);
    send_sample(24'd9085466, '0);
    send_sample(24'd9085466, RAW_MAX);
    send_sample('0, 24'd8569150);
    send_sample(RAW_MAX, 24'd8569150);
    send_sample(RAW_MAX, '0);
    settle();

    // same words, second order off
    load_calibration(1'b0, 1'b0);
    cal_sets++;
    send_sample(24'd9085466, 24'd8166784);
    send_sample(24'd9085466, 24'd6566784);
    send_sample(RAW_MAX, '0);
    settle();

    foreach (cal_words[k]) cal_words[k] = '1;
    load_calibration(1'b1, 1'b1);
    cal_sets++;
    send_sample(RAW_MAX, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample('0, '0);
    send_sample('0, RAW_MAX);
    settle();

    foreach (cal_words[k]) cal_words[k] = '0;
    load_calibration(1'b0, 1'b0);
    cal_sets++;
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(RAW_MAX, raw_t'($urandom_range(0, RAW_MAX)));
    settle();

    for (int s = 0; s < RANDOM_SETS; s++) begin
      set_typical();
      foreach (cal_words[k]) cal_words[k] = pick_word(cal_words[k]);
      load_calibration(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
      cal_sets++;
      for (int i = 0; i < SET_REQUESTS; i++) begin
        if (i % 20 == 0) begin
          in_no_gap    = ($urandom_range(0, 3) == 0);
          out_no_stall = ($urandom_range(0, 3) == 0);
        end
        if (s == 2 && i == SET_REQUESTS / 2)
          settle();
        random_pair(d1, d2);
        send_sample(d1, d2);
      end
      settle();
    end

    repeat (bptc_pkg::PIPE_DEPTH + 4) @(posedge clk);
    $display("covered %0d requests under %0d calibration sets", sb.requests, cal_sets);
    $display("second-order correction on %0d of them, %0d below -15 C",
             sb.low_temp_cases, sb.deep_cold_cases);
    if (sb.errors == 0)
      $display("[baro_pressure_temp_compensation_top] OK");
    else
      $display("[baro_pressure_temp_compensation_top] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bptc_pkg.sv
hw/rtl/bptc_in_if.sv
hw/rtl/bptc_out_if.sv
hw/rtl/bptc_cfg_if.sv
hw/rtl/baro_pressure_temp_compensation_top.sv
hw/rtl/bptc_checker.sv
sim/tb_baro_pressure_temp_compensation_top.sv
